// File: hw/rtl/dcds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcds_pkg: shared types and constants of the distance-culled dense set
// Widths, action and register codes, and the controller/datapath link.
// ----------------------------------------------------------------------------
package dcds_pkg;

   localparam int NUM_OBJECTS = 4096;

   localparam int ID_W    = 12;
   localparam int SLOT_W  = 12;
   localparam int COUNT_W = 13;
   localparam int COORD_W = 24;
   localparam int DIST_W  = 23;
   localparam int MAG_W   = COORD_W + 1;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int CSR_W   = 24;
   localparam int CSR_IDX_W = 3;

   // Squarer passes per item: dx, dy, dz, add, add+slop
   localparam int RUN_STEPS = 5;
   localparam int STEP_W    = 3;

   localparam logic [1:0] ACT_NONE      = 2'd0;
   localparam logic [1:0] ACT_APPEND    = 2'd1;
   localparam logic [1:0] ACT_DROP_LAST = 2'd2;
   localparam logic [1:0] ACT_DROP_MOVE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_VIEWER_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEWER_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEWER_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ADD_DIST = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOP_DIST = 3'd4;

   typedef struct packed {
      logic              clear;
      logic              load;
      logic              run;
      logic [STEP_W-1:0] step;
      logic              decide;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
   } dp_status_type;

endpackage
`default_nettype wire

// File: hw/rtl/dcds_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcds_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module dcds_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]         wr_data,
   input  wire  [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// File: hw/rtl/dcds_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcds_ctrl: sequencer of the distance-culled dense set
// Clears the maps after reset, then runs each item through the datapath.
// ----------------------------------------------------------------------------
module dcds_ctrl
   import dcds_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  wire           start,
   output logic          busy,
   output logic          rsp_valid,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_RUN    = 2'd2;
   localparam logic [1:0] ST_DECIDE = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              valid_ff, valid_in;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      valid_in   = 1'b0;
      cmd        = '0;
      cmd.step   = step_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.run = 1'b1;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(RUN_STEPS - 1)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            valid_in   = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule
`default_nettype wire

// File: hw/rtl/dcds_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcds_datapath: distance math, id/slot maps and set count
// Shared squarer, two map RAMs, decision and result registers.
// ----------------------------------------------------------------------------
module dcds_datapath
   import dcds_pkg::*;
(
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         csr_we,
   input  wire        [CSR_IDX_W-1:0]  csr_index,
   input  wire        [CSR_W-1:0]      csr_wdata,
   input  wire        [ID_W-1:0]       req_object_id,
   input  wire signed [COORD_W-1:0]    req_center_x,
   input  wire signed [COORD_W-1:0]    req_center_y,
   input  wire signed [COORD_W-1:0]    req_center_z,
   input  dp_cmd_type                  cmd,
   output dp_status_type               status,
   output logic       [1:0]            rsp_action,
   output logic       [SLOT_W-1:0]     rsp_slot,
   output logic       [ID_W-1:0]       rsp_source_id,
   output logic       [COUNT_W-1:0]    rsp_active_count
);

   function automatic logic [MAG_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
      logic [MAG_W-1:0] d;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      return d[MAG_W-1] ? (~d + MAG_W'(1)) : d;
   endfunction

   // Configuration
   logic [COORD_W-1:0] viewer_x_ff, viewer_y_ff, viewer_z_ff;
   logic [DIST_W-1:0]  add_ff, slop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         viewer_x_ff <= '0;
         viewer_y_ff <= '0;
         viewer_z_ff <= '0;
         add_ff      <= '0;
         slop_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VIEWER_X:  viewer_x_ff <= csr_wdata;
            CSR_VIEWER_Y:  viewer_y_ff <= csr_wdata;
            CSR_VIEWER_Z:  viewer_z_ff <= csr_wdata;
            CSR_ADD_DIST:  add_ff      <= csr_wdata[DIST_W-1:0];
            CSR_SLOP_DIST: slop_ff     <= csr_wdata[DIST_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Item registers
   logic [ID_W-1:0]  id_ff;
   logic [MAG_W-1:0] dx_ff, dy_ff, dz_ff, add_mag_ff, rem_mag_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff      <= req_object_id;
         dx_ff      <= abs_diff(req_center_x, viewer_x_ff);
         dy_ff      <= abs_diff(req_center_y, viewer_y_ff);
         dz_ff      <= abs_diff(req_center_z, viewer_z_ff);
         add_mag_ff <= MAG_W'(add_ff);
         rem_mag_ff <= MAG_W'(add_ff) + MAG_W'(slop_ff);
      end
   end

   // Shared squarer; accumulate one pass behind
   logic [MAG_W-1:0] sq_in;
   logic [SQ_W-1:0]  prod_ff, dist_ff, add2_ff;

   always_comb begin
      case (cmd.step)
         STEP_W'(0): sq_in = dx_ff;
         STEP_W'(1): sq_in = dy_ff;
         STEP_W'(2): sq_in = dz_ff;
         STEP_W'(3): sq_in = add_mag_ff;
         default:    sq_in = rem_mag_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.run) begin
         prod_ff <= SQ_W'(sq_in) * SQ_W'(sq_in);
         case (cmd.step)
            STEP_W'(1): dist_ff <= prod_ff;
            STEP_W'(2): dist_ff <= dist_ff + prod_ff;
            STEP_W'(3): dist_ff <= dist_ff + prod_ff;
            STEP_W'(4): add2_ff <= prod_ff;
            default: begin
            end
         endcase
      end
   end

   // Map memories and count
   logic [SLOT_W-1:0]  clr_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] last;
   logic [SLOT_W-1:0]  a_rdata;
   logic [ID_W-1:0]    b_rdata;
   logic [SLOT_W-1:0]  to_ff;
   logic [ID_W-1:0]    chk_ff, moved_ff;

   logic               a_we, b_we;
   logic [ID_W-1:0]    a_waddr;
   logic [SLOT_W-1:0]  a_wdata, b_waddr, b_raddr;
   logic [ID_W-1:0]    b_wdata;

   assign last = count_ff - COUNT_W'(1);
   assign b_raddr = (cmd.step == STEP_W'(1)) ? a_rdata : last[SLOT_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.run) begin
         case (cmd.step)
            STEP_W'(1): to_ff    <= a_rdata;
            STEP_W'(2): chk_ff   <= b_rdata;
            STEP_W'(3): moved_ff <= b_rdata;
            default: begin
            end
         endcase
      end
   end

   // Decision
   logic in_range, present, remove, to_is_last, append;
   logic [1:0]        action_in;
   logic [SLOT_W-1:0] slot_in;
   logic [ID_W-1:0]   src_in;

   always_comb begin
      in_range   = {1'b0, id_ff} < COUNT_W'(NUM_OBJECTS);
      present    = ({1'b0, to_ff} < count_ff) && (chk_ff == id_ff);
      remove     = in_range && present && (dist_ff > prod_ff);
      to_is_last = ({1'b0, to_ff} == last);
      append     = in_range && !present && (dist_ff < add2_ff)
                   && (count_ff < COUNT_W'(NUM_OBJECTS));
      action_in  = ACT_NONE;
      slot_in    = '0;
      src_in     = '0;
      count_in   = count_ff;
      if (remove) begin
         count_in = last;
         if (to_is_last) begin
            action_in = ACT_DROP_LAST;
            slot_in   = last[SLOT_W-1:0];
         end else begin
            action_in = ACT_DROP_MOVE;
            slot_in   = to_ff;
            src_in    = moved_ff;
         end
      end else if (append) begin
         action_in = ACT_APPEND;
         slot_in   = count_ff[SLOT_W-1:0];
         src_in    = id_ff;
         count_in  = count_ff + COUNT_W'(1);
      end
   end

   always_comb begin
      if (cmd.clear) begin
         a_we    = 1'b1;
         a_waddr = clr_ff;
         a_wdata = clr_ff;
         b_we    = 1'b1;
         b_waddr = clr_ff;
         b_wdata = clr_ff;
      end else if (append) begin
         a_we    = cmd.decide;
         a_waddr = id_ff;
         a_wdata = count_ff[SLOT_W-1:0];
         b_we    = cmd.decide;
         b_waddr = count_ff[SLOT_W-1:0];
         b_wdata = id_ff;
      end else begin
         a_we    = cmd.decide && remove && !to_is_last;
         a_waddr = moved_ff;
         a_wdata = to_ff;
         b_we    = a_we;
         b_waddr = to_ff;
         b_wdata = moved_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff   <= '0;
         count_ff <= COUNT_W'(NUM_OBJECTS);
      end else begin
         if (cmd.clear) begin
            clr_ff <= clr_ff + SLOT_W'(1);
         end
         if (cmd.decide) begin
            count_ff <= count_in;
         end
      end
   end

   assign status.clear_last = (clr_ff == SLOT_W'(NUM_OBJECTS - 1));

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         rsp_action       <= action_in;
         rsp_slot         <= slot_in;
         rsp_source_id    <= src_in;
         rsp_active_count <= count_in;
      end
   end

   dcds_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (NUM_OBJECTS)
   ) u_slot_of_id (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (a_wdata),
      .rd_addr (id_ff),
      .rd_data (a_rdata)
   );

   dcds_ram #(
      .WIDTH (ID_W),
      .DEPTH (NUM_OBJECTS)
   ) u_id_of_slot (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_data (b_wdata),
      .rd_addr (b_raddr),
      .rd_data (b_rdata)
   );

endmodule
`default_nettype wire

// File: hw/rtl/distance_culled_dense_set.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// distance_culled_dense_set: dense object set culled by viewer distance
// Keeps a packed set of object ids, adding near objects and swap-removing far
// ones with hysteresis between the add and remove radii.
//
// Usage:
//   Write viewer_x/y/z, add_distance and slop_distance on the csr_ port
//   (csr_we, csr_index, csr_wdata) while the block is idle; a write takes
//   effect at the clock edge, indexes past the list are ignored.
//   Drive req_object_id and req_center_x/y/z and raise start; a transfer is
//   taken at an edge where start is high and busy is low.
//   Exactly one result per transfer appears on the rsp_ ports, marked by
//   rsp_valid for a single cycle. There is no backpressure: sample it then.
//   Sequence: the item is loaded at the accepting edge, then makes five
//   passes through the one shared 25x25 squarer (three axes, add radius,
//   remove radius) and a decide step; the map RAM reads overlap those
//   passes. rsp_valid rises in the same cycle that busy drops, so a new
//   transfer is taken only once the last one has its result.
//   Reset: every id starts present at its own slot. After reset a clearing
//   pass writes both maps to identity, one entry a cycle, over all 4096 ids;
//   busy stays high until it ends. Configuration writes are taken meanwhile.
// ----------------------------------------------------------------------------
module distance_culled_dense_set
   import dcds_pkg::*;
(
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         csr_we,
   input  wire        [CSR_IDX_W-1:0]  csr_index,
   input  wire        [CSR_W-1:0]      csr_wdata,
   input  wire                         start,
   output logic                        busy,
   input  wire        [ID_W-1:0]       req_object_id,
   input  wire signed [COORD_W-1:0]    req_center_x,
   input  wire signed [COORD_W-1:0]    req_center_y,
   input  wire signed [COORD_W-1:0]    req_center_z,
   output logic                        rsp_valid,
   output logic       [1:0]            rsp_action,
   output logic       [SLOT_W-1:0]     rsp_slot,
   output logic       [ID_W-1:0]       rsp_source_id,
   output logic       [COUNT_W-1:0]    rsp_active_count
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer: clear pass, then load / run / decide for each transfer
   dcds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath: squared distances, map RAMs, count and result registers
   dcds_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_object_id    (req_object_id),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_center_z     (req_center_z),
      .cmd              (cmd),
      .status           (status),
      .rsp_action       (rsp_action),
      .rsp_slot         (rsp_slot),
      .rsp_source_id    (rsp_source_id),
      .rsp_active_count (rsp_active_count)
   );

   // A result only ever closes out a busy period
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a preceding busy period");

   // An accepted transfer holds off the next one
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an accepted transfer");

   // The set never holds more objects than there are ids
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_active_count <= COUNT_W'(NUM_OBJECTS)))
      else $error("active count beyond the number of objects");

   // An append always lands in the slot just past the old end
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action == ACT_APPEND)
         |-> (rsp_active_count == {1'b0, rsp_slot} + COUNT_W'(1)))
      else $error("append slot does not match the new count");

endmodule
`default_nettype wire
